@@ sv/spdavg_pkg.sv @@
// Shared constants, types and a helper function for the speedometer frequency averager.
package spdavg_pkg;

  localparam int STORE_DEPTH_DEF = 26;

  localparam int FREQ_W     = 16;
  localparam int TIME_W     = 32;
  localparam int TICK_W     = 16;
  localparam int SPEED_W    = 16;
  localparam int OUT_FREQ_W = 12;
  localparam int DATA_W     = 17;
  localparam int SUM_W      = 21;
  localparam int WIN_W      = 5;

  localparam int IN_TDATA_W  = FREQ_W + TIME_W;
  localparam int OUT_FIELD_W = OUT_FREQ_W + SPEED_W + 1;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int DVD_W = 28;
  localparam int DVS_W = 16;

  localparam logic [TICK_W-1:0]  TIMEOUT_RST   = 16'd500;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 16'd100;
  localparam logic [FREQ_W-1:0]  MAX_FREQ_RST  = 16'd1000;

  localparam logic [DATA_W-1:0] DATA_BIAS    = 17'd2;
  localparam logic [TICK_W:0]   STALE_MARGIN = 17'd10;
  localparam logic [DATA_W-1:0] ODO_OFF_TH   = 17'd3000;
  localparam logic [DATA_W-1:0] ODO_ON_TH    = 17'd2950;

  localparam logic [DATA_W-1:0] WIN_TH_25 = 17'd100;
  localparam logic [DATA_W-1:0] WIN_TH_10 = 17'd50;
  localparam logic [DATA_W-1:0] WIN_TH_5  = 17'd30;
  localparam logic [DATA_W-1:0] WIN_TH_3  = 17'd10;
  localparam logic [DATA_W-1:0] WIN_TH_2  = 17'd5;

  localparam logic [WIN_W-1:0] WIN_25 = 5'd25;
  localparam logic [WIN_W-1:0] WIN_10 = 5'd10;
  localparam logic [WIN_W-1:0] WIN_5  = 5'd5;
  localparam logic [WIN_W-1:0] WIN_3  = 5'd3;
  localparam logic [WIN_W-1:0] WIN_2  = 5'd2;
  localparam logic [WIN_W-1:0] WIN_1  = 5'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_MAX_SPEED = 2'd1,
    CFG_MAX_FREQ  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [WIN_W-1:0] pick_window(input logic [DATA_W-1:0] v);
    logic [WIN_W-1:0] w;
    if (v > WIN_TH_25)     w = WIN_25;
    else if (v > WIN_TH_10) w = WIN_10;
    else if (v > WIN_TH_5)  w = WIN_5;
    else if (v > WIN_TH_3)  w = WIN_3;
    else if (v > WIN_TH_2)  w = WIN_2;
    else                    w = WIN_1;
    return w;
  endfunction

endpackage

@@ sv/speedo_adaptive_freq_average_core.sv @@
// Speedometer frequency averager: top level with poll sequencer and datapath.
//
// One poll is taken at a time and yields one result. Only a poll that closes a
// window of W samples sweeps the sample store (one entry read and shifted per
// cycle) and runs the shared divider for the mean; the divider, which produces two
// quotient bits per cycle, also runs once per poll for the speed scaling unless
// max_frequency is zero. A finished result waits in the output register while the
// next poll is already accepted; a second result that finds the register still
// full holds the sequencer and the input. Configuration writes are taken at any
// time (cfg_ready stays high) and must only be issued while the block is idle.
// The sample store needs no clearing pass after reset.
module speedo_adaptive_freq_average_core #(
  parameter int STORE_DEPTH = spdavg_pkg::STORE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] measured_freq, [47:16] time_now
  input  logic [spdavg_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] captured
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [11:0] frequency, [27:12] vehicle_speed, [28] odo_enable, [31:29] zero
  output logic [spdavg_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spdavg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spdavg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int ADDR_W     = $clog2(STORE_DEPTH);
  localparam int FILL_W     = $clog2(STORE_DEPTH + 1);
  localparam int FREQ_W     = spdavg_pkg::FREQ_W;
  localparam int TIME_W     = spdavg_pkg::TIME_W;
  localparam int TICK_W     = spdavg_pkg::TICK_W;
  localparam int SPEED_W    = spdavg_pkg::SPEED_W;
  localparam int OUT_FREQ_W = spdavg_pkg::OUT_FREQ_W;
  localparam int DATA_W     = spdavg_pkg::DATA_W;
  localparam int SUM_W      = spdavg_pkg::SUM_W;
  localparam int WIN_W      = spdavg_pkg::WIN_W;
  localparam int DVD_W      = spdavg_pkg::DVD_W;
  localparam int DVS_W      = spdavg_pkg::DVS_W;
  localparam int OUT_PAD_W  = spdavg_pkg::OUT_TDATA_W - spdavg_pkg::OUT_FIELD_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_UPD   = 9'b000000010,
    S_PUSH  = 9'b000000100,
    S_SWEEP = 9'b000001000,
    S_DAVG  = 9'b000010000,
    S_ODO   = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_DSPD  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic [TICK_W-1:0]  timeout_r;
  logic [SPEED_W-1:0] max_speed_r;
  logic [FREQ_W-1:0]  max_freq_r;

  logic               cap_r;
  logic [FREQ_W-1:0]  meas_r;
  logic [TIME_W-1:0]  now_r;

  logic [FREQ_W-1:0]  latched_r;
  logic [TIME_W-1:0]  last_time_r;
  logic               valid_r;
  logic [FILL_W-1:0]  fill_r;
  logic [DATA_W-1:0]  avg_r;
  logic               odo_r;

  logic [WIN_W-1:0]   win_r;
  logic [SUM_W-1:0]   sum_r;
  logic [WIN_W-1:0]   rd_idx_r;
  logic [WIN_W-1:0]   rd_tag_r;
  logic               rd_pend_r;

  logic [OUT_FREQ_W-1:0] freq_r;
  logic [SPEED_W-1:0]    speed_r;

  logic               div_start_r;
  logic [DVD_W-1:0]   div_dvd_r;
  logic [DVS_W-1:0]   div_dvs_r;
  spdavg_pkg::div_req_t div_req;
  spdavg_pkg::div_rsp_t div_rsp;

  logic                              out_tvalid_r;
  logic [spdavg_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  logic [TIME_W-1:0]  gap;
  logic               gap_ok;
  logic               stale;
  logic [DATA_W-1:0]  data;
  logic [WIN_W-1:0]   win;
  logic [FILL_W-1:0]  fill_inc;
  logic               trig;
  logic               issue;
  logic               sweep_last;
  logic [SUM_W-1:0]   sum_fin;
  logic               out_load;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [DATA_W-1:0]  mem_rdata;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    gap      = now_r - last_time_r;
    gap_ok   = (gap <= TIME_W'(timeout_r));
    stale    = (gap >= TIME_W'({1'b0, timeout_r} + spdavg_pkg::STALE_MARGIN));
    data     = {1'b0, latched_r} + spdavg_pkg::DATA_BIAS;
    win      = spdavg_pkg::pick_window(data);
    fill_inc = fill_r + 1'b1;
    trig     = (fill_inc >= FILL_W'(win));
    issue    = (rd_idx_r < win_r);
    sweep_last = rd_pend_r && (rd_tag_r == win_r - WIN_W'(1));
    sum_fin  = sum_r + SUM_W'(mem_rdata);
    out_load = (state_r == S_OUT) && (!out_tvalid_r || out_tready);
  end

  // store port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_r[ADDR_W-1:0];
    mem_wdata = data;
    mem_re    = 1'b0;
    case (state_r)
      S_PUSH: begin
        mem_we = (fill_r < FILL_W'(STORE_DEPTH));
      end
      S_SWEEP: begin
        mem_re    = issue;
        mem_we    = rd_pend_r && (rd_tag_r != '0);
        mem_waddr = ADDR_W'(rd_tag_r - WIN_W'(1));
        mem_wdata = mem_rdata;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_UPD;
      S_UPD:   state_nxt = S_PUSH;
      S_PUSH:  state_nxt = trig ? S_SWEEP : S_ODO;
      S_SWEEP: if (sweep_last) state_nxt = S_DAVG;
      S_DAVG:  if (div_rsp.done) state_nxt = S_ODO;
      S_ODO:   state_nxt = S_MUL;
      S_MUL:   state_nxt = (max_freq_r == '0) ? S_OUT : S_DSPD;
      S_DSPD:  if (div_rsp.done) state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      timeout_r    <= spdavg_pkg::TIMEOUT_RST;
      max_speed_r  <= spdavg_pkg::MAX_SPEED_RST;
      max_freq_r   <= spdavg_pkg::MAX_FREQ_RST;
      latched_r    <= '0;
      last_time_r  <= '0;
      valid_r      <= 1'b0;
      fill_r       <= '0;
      avg_r        <= '0;
      odo_r        <= 1'b1;
      rd_pend_r    <= 1'b0;
      div_start_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_start_r <= 1'b0;

      if (cfg_valid) begin
        case (cfg_index)
          spdavg_pkg::CFG_TIMEOUT:   timeout_r   <= cfg_data;
          spdavg_pkg::CFG_MAX_SPEED: max_speed_r <= cfg_data;
          spdavg_pkg::CFG_MAX_FREQ:  max_freq_r  <= cfg_data;
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_UPD: begin
          if (cap_r) begin
            latched_r   <= meas_r;
            last_time_r <= now_r;
            if (gap_ok) valid_r <= 1'b1;
          end else if (stale) begin
            latched_r <= '0;
            valid_r   <= 1'b0;
            avg_r     <= '0;
          end
        end
        S_PUSH: begin
          rd_pend_r <= 1'b0;
          if (trig) begin
            fill_r <= FILL_W'(win - WIN_W'(1));
          end else begin
            fill_r <= fill_inc;
          end
        end
        S_SWEEP: begin
          rd_pend_r <= issue;
          if (sweep_last) begin
            div_start_r <= 1'b1;
          end
        end
        S_DAVG: begin
          if (div_rsp.done) begin
            avg_r <= div_rsp.quotient[DATA_W-1:0];
          end
        end
        S_ODO: begin
          if (avg_r >= spdavg_pkg::ODO_OFF_TH) begin
            odo_r <= 1'b0;
            avg_r <= '0;
          end else if (avg_r < spdavg_pkg::ODO_ON_TH) begin
            odo_r <= 1'b1;
          end
        end
        S_MUL: begin
          if (max_freq_r != '0) begin
            div_start_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cap_r  <= in_tuser;
        meas_r <= in_tdata[FREQ_W-1:0];
        now_r  <= in_tdata[FREQ_W +: TIME_W];
      end
      S_PUSH: begin
        win_r    <= win;
        sum_r    <= '0;
        rd_idx_r <= '0;
      end
      S_SWEEP: begin
        if (issue) begin
          rd_idx_r <= rd_idx_r + 1'b1;
          rd_tag_r <= rd_idx_r;
        end
        if (rd_pend_r) begin
          sum_r <= sum_fin;
        end
        div_dvd_r <= DVD_W'(sum_fin);
        div_dvs_r <= DVS_W'(win_r);
      end
      S_ODO: begin
        if (valid_r && (avg_r < spdavg_pkg::ODO_OFF_TH)) begin
          freq_r <= avg_r[OUT_FREQ_W-1:0];
        end else begin
          freq_r <= '0;
        end
      end
      S_MUL: begin
        div_dvd_r <= DVD_W'(freq_r) * DVD_W'(max_speed_r);
        div_dvs_r <= max_freq_r;
        speed_r   <= (freq_r != '0) ? max_speed_r : '0;
      end
      S_DSPD: begin
        if (div_rsp.quotient > DVD_W'(max_speed_r)) begin
          speed_r <= max_speed_r;
        end else begin
          speed_r <= div_rsp.quotient[SPEED_W-1:0];
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_tdata_r <= {{OUT_PAD_W{1'b0}}, odo_r, speed_r, freq_r};
        end
      end
      default: begin
      end
    endcase
  end

  assign div_req.start    = div_start_r;
  assign div_req.dividend = div_dvd_r;
  assign div_req.divisor  = div_dvs_r;

  spdavg_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (ADDR_W'(rd_idx_r)),
    .rdata (mem_rdata)
  );

  spdavg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

@@ sv/spdavg_store.sv @@
// Sample store: one write port and one registered read port.
module spdavg_store #(
  parameter int DEPTH = spdavg_pkg::STORE_DEPTH_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [ADDR_W-1:0]              waddr,
  input  logic [spdavg_pkg::DATA_W-1:0]  wdata,
  input  logic                           re,
  input  logic [ADDR_W-1:0]              raddr,
  output logic [spdavg_pkg::DATA_W-1:0]  rdata
);

  logic [spdavg_pkg::DATA_W-1:0] mem_r [DEPTH];
  logic [spdavg_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/spdavg_div.sv @@
// Shared restoring divider, two quotient bits per cycle.
module spdavg_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spdavg_pkg::div_req_t  req,
  output spdavg_pkg::div_rsp_t  rsp
);

  localparam int DVD_W = spdavg_pkg::DVD_W;
  localparam int DVS_W = spdavg_pkg::DVS_W;
  localparam int STEPS = DVD_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   t1;
  logic [DVS_W:0]   t2;
  logic             q1;
  logic             q2;
  logic [DVS_W-1:0] r1;
  logic [DVS_W-1:0] r2;
  logic [DVD_W-1:0] dvd_nxt;

  always_comb begin
    t1 = {rem_r, dvd_r[DVD_W-1]};
    q1 = (t1 >= {1'b0, dvs_r});
    r1 = q1 ? DVS_W'(t1 - {1'b0, dvs_r}) : t1[DVS_W-1:0];
    t2 = {r1, dvd_r[DVD_W-2]};
    q2 = (t2 >= {1'b0, dvs_r});
    r2 = q2 ? DVS_W'(t2 - {1'b0, dvs_r}) : t2[DVS_W-1:0];
    dvd_nxt = {dvd_r[DVD_W-3:0], q1, q2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= r2;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

@@ sv/spdavg_chk.sv @@
// Port-level checks for the speedometer frequency averager, bound to the top level.
module spdavg_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [spdavg_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // one poll in flight at a time
  a_one_poll: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a poll is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[11:0] == 12'd0) |-> (out_tdata[27:12] == 16'd0))
    else $error("nonzero speed with zero frequency");

  a_odo_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[11:0] != 12'd0) && (out_tdata[11:0] < 12'd2950)
      |-> out_tdata[28])
    else $error("odometer disabled below the enable threshold");

endmodule

bind speedo_adaptive_freq_average_core spdavg_chk u_spdavg_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
